/* src/lc3b_pkg.sv */
// Package for the LC-3b machine-cycle block: commands, control word fields, helpers.
// No dependencies; used by every module under src.
package lc3b_pkg;
   localparam int MEM_WORDS_DEF = 32768;
   localparam int CS_ROWS_DEF = 64;
   localparam int CW_W = 35;
   localparam logic [5:0] RESTART_STATE = 6'd18;

   localparam logic [2:0] CMD_LOAD_ROW = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_READ = 3'd2;
   localparam logic [2:0] CMD_RESTART = 3'd3;
   localparam logic [2:0] CMD_TICK = 3'd4;

   localparam int B_IRD = 34;
   localparam int B_LD_MAR = 25;
   localparam int B_LD_MDR = 24;
   localparam int B_LD_IR = 23;
   localparam int B_LD_BEN = 22;
   localparam int B_LD_REG = 21;
   localparam int B_LD_CC = 20;
   localparam int B_LD_PC = 19;
   localparam int B_GATE_PC = 18;
   localparam int B_GATE_MDR = 17;
   localparam int B_GATE_ALU = 16;
   localparam int B_GATE_MARMUX = 15;
   localparam int B_GATE_SHF = 14;
   localparam int B_DRMUX = 11;
   localparam int B_SR1MUX = 10;
   localparam int B_ADDR1MUX = 9;
   localparam int B_MARMUX = 6;
   localparam int B_MIO_EN = 3;
   localparam int B_R_W = 2;
   localparam int B_DATA_SIZE = 1;
   localparam int B_LSHF1 = 0;

   localparam logic [1:0] COND_READY = 2'd1;
   localparam logic [1:0] COND_BRANCH = 2'd2;
   localparam logic [1:0] COND_ADDR = 2'd3;

   typedef logic [CW_W-1:0] cw_type;

   typedef struct packed {
      logic        we;
      logic [1:0]  be;
      logic [15:0] wdata;
   } mem_wr_type;

   function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
      logic [15:0] r;
      r = v;
      for (int i = 0; i < 16; i++) begin
         if (i >= bits) r[i] = v[bits-1];
      end
      return r;
   endfunction
endpackage

/* src/lc3b_cstore.sv */
// Control store: 64 x 35 synchronous memory, one write and one read port.
// Depends on lc3b_pkg.
module lc3b_cstore #(
   parameter int CS_ROWS = lc3b_pkg::CS_ROWS_DEF
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [5:0]          wr_row,
   input  lc3b_pkg::cw_type    wr_data,
   input  logic [5:0]          rd_row,
   output lc3b_pkg::cw_type    rd_data
);
   lc3b_pkg::cw_type mem_ff [CS_ROWS];
   lc3b_pkg::cw_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_row] <= wr_data;
      rd_ff <= mem_ff[rd_row];
   end
   assign rd_data = rd_ff;
endmodule

/* src/lc3b_mainmem.sv */
// Main memory with a clearing pass after reset; byte write enables, registered read.
// Depends on lc3b_pkg.
module lc3b_mainmem #(
   parameter int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF,
   parameter int AW = $clog2(MEM_WORDS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lc3b_pkg::mem_wr_type wr,
   input  logic [AW-1:0]        addr,
   output logic [15:0]          rd_data,
   output logic                 clearing
);
   logic [15:0] mem_ff [MEM_WORDS];
   logic [15:0] rd_ff;
   logic [AW:0] clr_ff;
   logic [AW:0] clr_in;
   logic        busy;

   assign busy = !clr_ff[AW];
   assign clr_in = busy ? clr_ff + 1'b1 : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         mem_ff[clr_ff[AW-1:0]] <= 16'h0000;
      end else if (wr.we) begin
         if (wr.be[0]) mem_ff[addr][7:0] <= wr.wdata[7:0];
         if (wr.be[1]) mem_ff[addr][15:8] <= wr.wdata[15:8];
      end
      rd_ff <= mem_ff[addr];
   end
   assign rd_data = rd_ff;
   assign clearing = busy;
endmodule

/* src/lc3b_datapath.sv */
// Datapath for one machine cycle: bus drivers, sequencer, latch next values.
// Depends on lc3b_pkg; combinational.
module lc3b_datapath (
   input  lc3b_pkg::cw_type w,
   input  logic [15:0] ir,
   input  logic [15:0] pc,
   input  logic [15:0] mar,
   input  logic [15:0] mdr,
   input  logic [15:0] mem_word,
   input  logic [2:0]  cc,
   input  logic        ben,
   input  logic        ready,
   input  logic [2:0]  count,
   input  logic [15:0] rf [8],
   output logic [5:0]  ns,
   output logic [15:0] bus,
   output logic [15:0] next_pc,
   output logic [15:0] next_mdr,
   output logic [2:0]  next_cc,
   output logic        next_ben,
   output logic        next_ready,
   output logic [2:0]  next_count,
   output lc3b_pkg::mem_wr_type mem_wr
);
   logic [5:0]  j;
   logic [15:0] sr1, sr2, a1, a2, adder, alu, shf;
   logic [3:0]  sh;
   logic        word_size;

   always_comb begin
      word_size = w[lc3b_pkg::B_DATA_SIZE];
      j = w[31:26];
      if (w[33:32] == lc3b_pkg::COND_READY && ready) j[1] = 1'b1;
      if (w[33:32] == lc3b_pkg::COND_BRANCH && ben) j[2] = 1'b1;
      if (w[33:32] == lc3b_pkg::COND_ADDR && ir[11]) j[0] = 1'b1;
      ns = w[lc3b_pkg::B_IRD] ? {2'b00, ir[15:12]} : j;

      next_ready = ready;
      next_count = count;
      next_mdr = mdr;
      mem_wr.we = 1'b0;
      mem_wr.be = 2'b00;
      mem_wr.wdata = mdr;
      if (w[lc3b_pkg::B_MIO_EN]) begin
         if (ready) begin
            if (w[lc3b_pkg::B_R_W]) begin
               mem_wr.we = 1'b1;
               mem_wr.be = {word_size | mar[0], word_size | !mar[0]};
            end else if (w[lc3b_pkg::B_LD_MDR]) begin
               next_mdr = mem_word;
            end
            next_count = 3'd0;
            next_ready = 1'b0;
         end else if (count < 3'd5) begin
            next_count = count + 3'd1;
            if (next_count == 3'd4) next_ready = 1'b1;
         end
      end

      sr1 = rf[w[lc3b_pkg::B_SR1MUX] ? ir[8:6] : ir[11:9]];
      sr2 = ir[5] ? lc3b_pkg::sext(ir, 5) : rf[ir[2:0]];
      a1 = w[lc3b_pkg::B_ADDR1MUX] ? rf[ir[8:6]] : pc;
      unique case (w[8:7])
         2'd1: a2 = lc3b_pkg::sext(ir, 6);
         2'd2: a2 = lc3b_pkg::sext(ir, 9);
         2'd3: a2 = lc3b_pkg::sext(ir, 11);
         default: a2 = 16'h0000;
      endcase
      if (w[lc3b_pkg::B_LSHF1]) a2 = {a2[14:0], 1'b0};
      adder = a1 + a2;

      unique case (w[5:4])
         2'd0: alu = sr1 + sr2;
         2'd1: alu = sr1 & sr2;
         2'd2: alu = sr1 ^ sr2;
         default: alu = sr1;
      endcase
      sh = ir[3:0];
      unique case (ir[5:4])
         2'd0: shf = sr1 << sh;
         2'd1: shf = sr1 >> sh;
         2'd3: shf = 16'($signed(sr1) >>> sh);
         default: shf = 16'h0000;
      endcase

      priority if (w[lc3b_pkg::B_GATE_MARMUX])
         bus = w[lc3b_pkg::B_MARMUX] ? adder : {7'd0, ir[7:0], 1'b0};
      else if (w[lc3b_pkg::B_GATE_PC]) bus = pc;
      else if (w[lc3b_pkg::B_GATE_ALU]) bus = alu;
      else if (w[lc3b_pkg::B_GATE_SHF]) bus = shf;
      else if (w[lc3b_pkg::B_GATE_MDR])
         bus = word_size ? mdr :
               (mar[0] ? lc3b_pkg::sext({8'd0, mdr[15:8]}, 8) : lc3b_pkg::sext(mdr, 8));
      else bus = 16'h0000;

      next_pc = pc;
      if (w[lc3b_pkg::B_LD_PC]) begin
         unique case (w[13:12])
            2'd0: next_pc = pc + 16'd2;
            2'd1: next_pc = bus;
            2'd2: next_pc = adder;
            default: next_pc = pc;
         endcase
      end
      if (w[lc3b_pkg::B_LD_MDR] && !w[lc3b_pkg::B_MIO_EN])
         next_mdr = word_size ? bus : {bus[7:0], bus[7:0]};
      next_cc = cc;
      if (w[lc3b_pkg::B_LD_CC])
         next_cc = (bus == 16'h0000) ? 3'b010 : (bus[15] ? 3'b100 : 3'b001);
      next_ben = w[lc3b_pkg::B_LD_BEN] ? |(ir[11:9] & cc) : ben;
   end
endmodule

/* src/lc3b_microcoded_cpu_cycle_top.sv */
// LC-3b machine-cycle block: one transaction per command, one response per transaction.
// A transaction first issues the control-store and main-memory reads (synchronous
// memories), then executes and registers the response. A new transaction is taken at the
// edge where the previous response is accepted; while a response is stalled the input
// stalls too. The current microinstruction is held in a register, loaded from the control
// store after a restart or an executed tick. After reset the main memory is cleared one
// word per cycle before any transaction is taken.
// Depends on lc3b_pkg, lc3b_cstore, lc3b_mainmem, lc3b_datapath.
module lc3b_microcoded_cpu_cycle_top #(
   parameter int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF,
   parameter int CS_ROWS = lc3b_pkg::CS_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [5:0]  req_row_index,
   input  logic [34:0] req_control_word,
   input  logic [14:0] req_word_address,
   input  logic [15:0] req_word_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_state_number,
   output logic [15:0] rsp_program_counter,
   output logic [15:0] rsp_instruction_register,
   output logic [15:0] rsp_bus_value,
   output logic [2:0]  rsp_condition_codes,
   output logic        rsp_halted,
   output logic [15:0] rsp_read_data,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   localparam int AW = $clog2(MEM_WORDS);

   logic        ex_ff, ex_in;
   logic [2:0]  cmd_ff;
   logic [15:0] start_ff;
   logic [15:0] pc_ff, ir_ff, mar_ff, mdr_ff;
   logic [2:0]  cc_ff, cnt_ff;
   logic        ben_ff, rdy_ff;
   logic [5:0]  st_ff;
   logic        uwl_ff;
   lc3b_pkg::cw_type uw_ff;
   logic [15:0] rf_ff [8];
   logic        ov_ff;
   logic [15:0] bus_r_ff, rd_r_ff;

   logic        accept, clearing, tick_run;
   logic [5:0]  cs_rd_row;
   lc3b_pkg::cw_type cs_q, w;
   logic [AW-1:0] maddr;
   logic [15:0] mem_q;
   lc3b_pkg::mem_wr_type dp_wr, mwr;
   logic [5:0]  ns;
   logic [15:0] bus, npc, nmdr;
   logic [2:0]  ncc, ncnt;
   logic        nben, nrdy;

   assign req_stall = clearing || ex_ff || (ov_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign ex_in = accept;

   assign w = uw_ff;
   assign tick_run = ex_ff && cmd_ff == lc3b_pkg::CMD_TICK && pc_ff != 16'h0000;

   always_comb begin
      cs_rd_row = tick_run ? ns : lc3b_pkg::RESTART_STATE;
      if (accept && (req_command == lc3b_pkg::CMD_WRITE ||
                     req_command == lc3b_pkg::CMD_READ))
         maddr = req_word_address[AW-1:0];
      else maddr = mar_ff[AW:1];
      mwr = dp_wr;
      mwr.we = tick_run && dp_wr.we;
      if (accept && req_command == lc3b_pkg::CMD_WRITE) begin
         mwr.we = 1'b1;
         mwr.be = 2'b11;
         mwr.wdata = req_word_data;
      end
   end

   lc3b_cstore #(.CS_ROWS(CS_ROWS)) u_cs (
      .clock(clock), .wr_en(accept && req_command == lc3b_pkg::CMD_LOAD_ROW),
      .wr_row(req_row_index), .wr_data(req_control_word),
      .rd_row(cs_rd_row), .rd_data(cs_q)
   );

   lc3b_mainmem #(.MEM_WORDS(MEM_WORDS), .AW(AW)) u_mem (
      .clock(clock), .reset(reset), .wr(mwr), .addr(maddr),
      .rd_data(mem_q), .clearing(clearing)
   );

   lc3b_datapath u_dp (
      .w(w), .ir(ir_ff), .pc(pc_ff), .mar(mar_ff), .mdr(mdr_ff), .mem_word(mem_q),
      .cc(cc_ff), .ben(ben_ff), .ready(rdy_ff), .count(cnt_ff), .rf(rf_ff),
      .ns(ns), .bus(bus), .next_pc(npc), .next_mdr(nmdr), .next_cc(ncc),
      .next_ben(nben), .next_ready(nrdy), .next_count(ncnt), .mem_wr(dp_wr)
   );

   always_ff @(posedge clock) begin
      if (accept) cmd_ff <= req_command;
      if (reset) begin
         ex_ff <= 1'b0;
         ov_ff <= 1'b0;
         start_ff <= '0;
         pc_ff <= '0; ir_ff <= '0; mar_ff <= '0; mdr_ff <= '0;
         cc_ff <= 3'b010; cnt_ff <= '0; ben_ff <= 1'b0; rdy_ff <= 1'b0;
         st_ff <= lc3b_pkg::RESTART_STATE;
         uw_ff <= '0;
         uwl_ff <= 1'b0;
         for (int i = 0; i < 8; i++) rf_ff[i] <= '0;
      end else begin
         ex_ff <= ex_in;
         if (csr_write_enable) start_ff <= csr_write_data;
         if (ex_ff) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
         if (ex_ff) begin
            bus_r_ff <= tick_run ? bus : 16'h0000;
            rd_r_ff <= cmd_ff == lc3b_pkg::CMD_READ ? mem_q : 16'h0000;
         end
         // next row was read at the execute edge of the tick
         uwl_ff <= tick_run;
         if (uwl_ff) uw_ff <= cs_q;
         if (ex_ff && cmd_ff == lc3b_pkg::CMD_RESTART) begin
            pc_ff <= start_ff;
            st_ff <= lc3b_pkg::RESTART_STATE;
            cc_ff <= 3'b010;
            uw_ff <= cs_q;
         end
         if (tick_run) begin
            pc_ff <= npc;
            if (w[lc3b_pkg::B_LD_IR]) ir_ff <= bus;
            if (w[lc3b_pkg::B_LD_MAR]) mar_ff <= bus;
            mdr_ff <= nmdr;
            cc_ff <= ncc;
            ben_ff <= nben;
            rdy_ff <= nrdy;
            cnt_ff <= ncnt;
            st_ff <= ns;
            if (w[lc3b_pkg::B_LD_REG])
               rf_ff[w[lc3b_pkg::B_DRMUX] ? 3'd7 : ir_ff[11:9]] <= bus;
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_state_number = st_ff;
   assign rsp_program_counter = pc_ff;
   assign rsp_instruction_register = ir_ff;
   assign rsp_bus_value = bus_r_ff;
   assign rsp_condition_codes = cc_ff;
   assign rsp_halted = pc_ff == 16'h0000;
   assign rsp_read_data = rd_r_ff;

   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      ex_ff |=> !ex_ff) else $error("back-to-back execute");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !accept) else $error("accept during clear");
   a_rsp_after_ex: assert property (@(posedge clock) disable iff (reset)
      ex_ff |=> rsp_valid) else $error("response lost");
   a_cc_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(cc_ff)) else $error("condition codes not one-hot");
endmodule
